// File: design/sha_pad_pkg.sv
package sha_pad_pkg;

   localparam int unsigned WORD_W        = 32;
   localparam int unsigned BYTE_W        = 8;
   localparam int unsigned COUNT_W       = 64;
   localparam int unsigned SLOT_W        = 4;
   localparam int unsigned CMD_FIFO_DEPTH = 2;

   localparam logic [BYTE_W-1:0] MARKER_BYTE     = 8'h80;
   localparam logic [SLOT_W-1:0] LAST_ZERO_SLOT  = 4'd13;
   localparam logic [SLOT_W-1:0] SPILL_SLOT      = 4'd14;
   localparam logic [SLOT_W-1:0] SPILL_ZEROS_MAX = 4'd15;
   localparam logic [SLOT_W-1:0] SPILL_ZEROS_MIN = 4'd14;
   localparam logic [COUNT_W-1:0] BITS_PER_BYTE  = 64'd8;

   typedef struct packed {
      logic                has_word;
      logic                has_end;
      logic [WORD_W-1:0]   data_word;
      logic [WORD_W-1:0]   marker_word;
      logic [SLOT_W-1:0]   zero_words;
      logic [COUNT_W-1:0]  bit_count;
      logic                overflow;
   } cmd_type;

endpackage

// File: design/sha_pad_req_if.sv
interface sha_pad_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       ends_message;

   modport source (output valid, output data_byte, output has_byte, output ends_message,
                   input ready);
   modport sink (input valid, input data_byte, input has_byte, input ends_message,
                 output ready);
endinterface

// File: design/sha_pad_rsp_if.sv
interface sha_pad_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] word;
   logic        last_word;
   logic        length_overflow;

   modport source (output valid, output word, output last_word, output length_overflow,
                   input ready);
   modport sink (input valid, input word, input last_word, input length_overflow,
                 output ready);
endinterface

// File: design/sha_pad_front.sv
module sha_pad_front
   import sha_pad_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   sha_pad_req_if.sink    req_ch,
   input  logic           cmd_ready,
   output logic           cmd_push,
   output cmd_type        cmd_data
);

   logic [23:0]        partial_ff, partial_in;
   logic [1:0]         bytes_ff, bytes_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               ovf_ff, ovf_in;

   logic               accept;
   logic               word_done;
   logic [23:0]        held;
   logic [1:0]         held_bytes;
   logic [SLOT_W-1:0]  slot_after;
   logic [COUNT_W-1:0] count_after;
   logic               ovf_after;
   logic [WORD_W-1:0]  marker;
   logic [SLOT_W-1:0]  zeros;

   assign req_ch.ready = cmd_ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign word_done    = req_ch.has_byte && (bytes_ff == 2'd3);

   always_comb begin
      count_after = count_ff;
      ovf_after   = ovf_ff;
      held        = partial_ff;
      held_bytes  = bytes_ff;
      slot_after  = slot_ff;
      if (req_ch.has_byte) begin
         if (&count_ff[COUNT_W-1:3]) begin
            count_after = '1;
            ovf_after   = 1'b1;
         end else begin
            count_after = count_ff + BITS_PER_BYTE;
         end
         if (word_done) begin
            held       = '0;
            held_bytes = 2'd0;
            slot_after = slot_ff + 1'b1;
         end else begin
            held       = {partial_ff[15:0], req_ch.data_byte};
            held_bytes = bytes_ff + 1'b1;
         end
      end

      unique case (held_bytes)
         2'd0: marker = {MARKER_BYTE, 24'h0};
         2'd1: marker = {held[7:0], MARKER_BYTE, 16'h0};
         2'd2: marker = {held[15:0], MARKER_BYTE, 8'h0};
         default: marker = {held[23:0], MARKER_BYTE};
      endcase

      if (slot_after <= LAST_ZERO_SLOT) begin
         zeros = LAST_ZERO_SLOT - slot_after;
      end else if (slot_after == SPILL_SLOT) begin
         zeros = SPILL_ZEROS_MAX;
      end else begin
         zeros = SPILL_ZEROS_MIN;
      end
   end

   always_comb begin
      cmd_push             = accept && (word_done || req_ch.ends_message);
      cmd_data.has_word    = word_done;
      cmd_data.has_end     = req_ch.ends_message;
      cmd_data.data_word   = {partial_ff, req_ch.data_byte};
      cmd_data.marker_word = marker;
      cmd_data.zero_words  = zeros;
      cmd_data.bit_count   = count_after;
      cmd_data.overflow    = ovf_after;

      partial_in = partial_ff;
      bytes_in   = bytes_ff;
      slot_in    = slot_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      if (accept) begin
         if (req_ch.ends_message) begin
            partial_in = '0;
            bytes_in   = '0;
            slot_in    = '0;
            count_in   = '0;
            ovf_in     = 1'b0;
         end else begin
            partial_in = held;
            bytes_in   = held_bytes;
            slot_in    = slot_after;
            count_in   = count_after;
            ovf_in     = ovf_after;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         bytes_ff   <= '0;
         slot_ff    <= '0;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
      end else begin
         partial_ff <= partial_in;
         bytes_ff   <= bytes_in;
         slot_ff    <= slot_in;
         count_ff   <= count_in;
         ovf_ff     <= ovf_in;
      end
   end

endmodule

// File: design/sha_pad_fifo.sv
module sha_pad_fifo
   import sha_pad_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    push_ready,
   input  logic    pop,
   output cmd_type head,
   output logic    head_valid
);

   localparam int unsigned PTR_W = $clog2(CMD_FIFO_DEPTH);
   localparam int unsigned CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

   cmd_type            mem_ff [CMD_FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (count_ff != CNT_W'(CMD_FIFO_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: design/sha_pad_back.sv
module sha_pad_back
   import sha_pad_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       head,
   input  logic          head_valid,
   output logic          pop,
   sha_pad_rsp_if.source rsp_ch
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MARKER,
      ST_ZERO,
      ST_LEN_HI,
      ST_LEN_LO
   } state_type;

   state_type          state_ff, state_in;
   cmd_type            cur_ff, cur_in;
   logic [SLOT_W-1:0]  zeros_ff, zeros_in;
   logic               valid_ff, valid_in;
   logic [WORD_W-1:0]  word_ff, word_in;
   logic               last_ff, last_in;
   logic               ovf_ff, ovf_in;
   logic               out_free;

   assign out_free               = !valid_ff || rsp_ch.ready;
   assign rsp_ch.valid           = valid_ff;
   assign rsp_ch.word            = word_ff;
   assign rsp_ch.last_word       = last_ff;
   assign rsp_ch.length_overflow = ovf_ff;

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      zeros_in = zeros_ff;
      valid_in = valid_ff && !rsp_ch.ready;
      word_in  = word_ff;
      last_in  = last_ff;
      ovf_in   = ovf_ff;
      pop      = 1'b0;
      if (out_free) begin
         unique case (state_ff)
            ST_IDLE: begin
               if (head_valid) begin
                  pop      = 1'b1;
                  cur_in   = head;
                  zeros_in = head.zero_words;
                  valid_in = 1'b1;
                  last_in  = 1'b0;
                  ovf_in   = head.overflow;
                  if (head.has_word) begin
                     word_in  = head.data_word;
                     state_in = head.has_end ? ST_MARKER : ST_IDLE;
                  end else begin
                     word_in  = head.marker_word;
                     state_in = (head.zero_words != '0) ? ST_ZERO : ST_LEN_HI;
                  end
               end
            end
            ST_MARKER: begin
               valid_in = 1'b1;
               word_in  = cur_ff.marker_word;
               last_in  = 1'b0;
               ovf_in   = cur_ff.overflow;
               state_in = (zeros_ff != '0) ? ST_ZERO : ST_LEN_HI;
            end
            ST_ZERO: begin
               valid_in = 1'b1;
               word_in  = '0;
               last_in  = 1'b0;
               ovf_in   = cur_ff.overflow;
               zeros_in = zeros_ff - 1'b1;
               state_in = (zeros_ff == SLOT_W'(1)) ? ST_LEN_HI : ST_ZERO;
            end
            ST_LEN_HI: begin
               valid_in = 1'b1;
               word_in  = cur_ff.bit_count[COUNT_W-1:WORD_W];
               last_in  = 1'b0;
               ovf_in   = cur_ff.overflow;
               state_in = ST_LEN_LO;
            end
            ST_LEN_LO: begin
               valid_in = 1'b1;
               word_in  = cur_ff.bit_count[WORD_W-1:0];
               last_in  = 1'b1;
               ovf_in   = cur_ff.overflow;
               state_in = ST_IDLE;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      word_ff <= word_in;
      last_ff <= last_in;
      ovf_ff  <= ovf_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         zeros_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         zeros_ff <= zeros_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// File: design/sha256_message_padder_top.sv
// SHA-256 message padder with a byte-serial input and a 32-bit word output.
// The req_ch channel takes one item per cycle: a message byte (when has_byte
// is set) and an ends_message flag that closes the message after that byte.
// The rsp_ch channel delivers the padded message as big-endian words; the low
// length word carries last_word, and length_overflow flags a saturated count.
// A word made of four bytes passes through the command queue and the output
// register to rsp_ch. A closing item expands into the marker word, zero words up
// to word 14 of the block (spilling into another block if needed) and the two length
// words, up to 19 with its own data word, at one per cycle while rsp_ch is ready.
// Data items are taken at one per cycle; a two-entry command queue between the
// byte packer and the output sequencer lets the packer keep accepting while
// padding words drain, and req_ch.ready drops only when that queue is full.
// When the receiver stalls, the output register holds its word and the queue
// fills, after which the input is held off. Synchronous reset empties the
// queue, drops rsp_ch.valid and clears the partial word and bit count.
module sha256_message_padder_top
   import sha_pad_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   sha_pad_req_if.sink   req_ch,
   sha_pad_rsp_if.source rsp_ch
);

   logic    cmd_push;
   logic    cmd_ready;
   cmd_type cmd_data;
   logic    cmd_pop;
   cmd_type cmd_head;
   logic    cmd_valid;

   sha_pad_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cmd_ready (cmd_ready),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_data)
   );

   sha_pad_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_data  (cmd_data),
      .push_ready (cmd_ready),
      .pop        (cmd_pop),
      .head       (cmd_head),
      .head_valid (cmd_valid)
   );

   sha_pad_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (cmd_head),
      .head_valid (cmd_valid),
      .pop        (cmd_pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

// File: bench/testbench.sv
module testbench;
   import sha_pad_pkg::*;

   localparam int unsigned CLOCK_HIGH     = 6;
   localparam int unsigned CLOCK_LOW      = 6;
   localparam int unsigned RESET_CYCLES   = 12;
   localparam int unsigned MAX_WAIT       = 18;
   localparam int unsigned RANDOM_ITEMS   = 220;
   localparam int unsigned LONG_HOLD      = 500;
   localparam int unsigned HOLD_AFTER     = 30;
   localparam int unsigned PAUSE_MESSAGE  = 3;
   localparam int unsigned DRAIN_CYCLES   = 60;
   localparam int unsigned CYCLE_LIMIT    = 600000;

   localparam logic [7:0]  PAD_MARKER     = 8'h80;
   localparam int unsigned LENGTH_SLOT    = 14;
   localparam int unsigned SLOTS_PER_BLOCK = 16;
   localparam logic [63:0] LAST_SAFE_COUNT = 64'hFFFF_FFFF_FFFF_FFF7;

   class padder_scoreboard;
      typedef struct {
         logic [31:0] word;
         logic        last_word;
         logic        length_overflow;
      } padded_word_type;

      logic [23:0]     held_bytes;
      logic [1:0]      held_count;
      logic [3:0]      block_slot;
      logic [63:0]     message_bits;
      logic            count_saturated;
      padded_word_type pending[$];
      int unsigned     mismatches;

      function new();
         clear_message();
         mismatches = 0;
      endfunction

      function void clear_message();
         held_bytes      = '0;
         held_count      = '0;
         block_slot      = '0;
         message_bits    = '0;
         count_saturated = 1'b0;
      endfunction

      function void push_word(logic [31:0] word, logic last_word);
         padded_word_type entry;
         entry.word            = word;
         entry.last_word       = last_word;
         entry.length_overflow = count_saturated;
         pending.push_back(entry);
      endfunction

      function void note_item(logic [7:0] data_byte, logic has_byte, logic ends_message);
         int unsigned filled;
         logic [31:0] marker_word;
         if (has_byte) begin
            if (message_bits > LAST_SAFE_COUNT) begin
               message_bits    = '1;
               count_saturated = 1'b1;
            end else begin
               message_bits = message_bits + 64'd8;
            end
            if (held_count == 2'd3) begin
               push_word({held_bytes, data_byte}, 1'b0);
               block_slot = block_slot + 4'd1;
               held_bytes = '0;
               held_count = '0;
            end else begin
               held_bytes = {held_bytes[15:0], data_byte};
               held_count = held_count + 2'd1;
            end
         end
         if (!ends_message) return;

         case (held_count)
            2'd0: marker_word = {PAD_MARKER, 24'h0};
            2'd1: marker_word = {held_bytes[7:0], PAD_MARKER, 16'h0};
            2'd2: marker_word = {held_bytes[15:0], PAD_MARKER, 8'h0};
            default: marker_word = {held_bytes, PAD_MARKER};
         endcase
         push_word(marker_word, 1'b0);
         filled = int'(block_slot) + 1;
         if (filled > LENGTH_SLOT) begin
            while (filled < SLOTS_PER_BLOCK) begin
               push_word(32'h0, 1'b0);
               filled++;
            end
            filled = 0;
         end
         while (filled < LENGTH_SLOT) begin
            push_word(32'h0, 1'b0);
            filled++;
         end
         push_word(message_bits[63:32], 1'b0);
         push_word(message_bits[31:0], 1'b1);
         clear_message();
      endfunction

      function void check_word(logic [31:0] word, logic last_word, logic length_overflow);
         padded_word_type exp;
         if (pending.size() == 0) begin
            $error("unexpected word %h with no item outstanding", word);
            mismatches++;
            return;
         end
         exp = pending.pop_front();
         if (word !== exp.word) begin
            $error("word mismatch: expected %h, got %h", exp.word, word);
            mismatches++;
         end
         if (last_word !== exp.last_word) begin
            $error("last_word mismatch: expected %0b, got %0b", exp.last_word, last_word);
            mismatches++;
         end
         if (length_overflow !== exp.length_overflow) begin
            $error("length_overflow mismatch: expected %0b, got %0b",
                   exp.length_overflow, length_overflow);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   sha_pad_req_if req_bus ();
   sha_pad_rsp_if rsp_bus ();

   padder_scoreboard sb;
   int unsigned items_sent;
   int unsigned cycle_count;
   bit          sender_quiet;
   bit          receiver_quiet;

   sha256_message_padder_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always begin
      clock = 1'b0;
      #CLOCK_LOW;
      clock = 1'b1;
      #CLOCK_HIGH;
   end

   initial begin
      cycle_count = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_item(req_bus.data_byte, req_bus.has_byte, req_bus.ends_message);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_word(rsp_bus.word, rsp_bus.last_word, rsp_bus.length_overflow);
      end
   end

   task automatic send_item(input logic [7:0] data_byte, input logic has_byte,
                            input logic ends_message);
      int unsigned gap;
      gap = sender_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.data_byte    <= data_byte;
      req_bus.has_byte     <= has_byte;
      req_bus.ends_message <= ends_message;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_message(input logic [7:0] msg[$], input bit end_on_byte);
      int unsigned idx;
      for (idx = 0; idx < msg.size(); idx++) begin
         if ($urandom_range(0, 9) == 0)
            send_item(8'($urandom), 1'b0, 1'b0);
         send_item(msg[idx], 1'b1, end_on_byte && (idx == msg.size() - 1));
      end
      if (!end_on_byte || msg.size() == 0) begin
         send_item(8'($urandom), 1'b0, 1'b1);
      end
   endtask

   task automatic wait_until_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned words_taken;
      int unsigned stall;
      words_taken    = 0;
      receiver_quiet = 1'b0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (words_taken == HOLD_AFTER)
            stall = LONG_HOLD;
         else if (receiver_quiet)
            stall = 0;
         else
            stall = $urandom_range(0, MAX_WAIT);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         words_taken++;
         if ($urandom_range(0, 15) == 0)
            receiver_quiet = !receiver_quiet;
      end
   end

   initial begin
      logic [7:0]  msg[$];
      int unsigned msg_len;
      int unsigned msg_count;
      sb = new();
      items_sent   = 0;
      msg_count    = 0;
      sender_quiet = 1'b0;
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.data_byte    <= 8'h00;
      req_bus.has_byte     <= 1'b0;
      req_bus.ends_message <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // An empty message, then items without a byte that must be ignored.
      msg = {};
      send_message(msg, 1'b0);
      send_item(8'hFF, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      msg = {8'hFF};
      send_message(msg, 1'b1);
      msg = {8'h00, 8'h7F};
      send_message(msg, 1'b0);
      msg = {8'h01, 8'h80, 8'hFE};
      send_message(msg, 1'b1);
      msg = {8'h12, 8'h34, 8'h56, 8'h78};
      send_message(msg, 1'b1);
      msg = {8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_message(msg, 1'b0);

      while (items_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 4))
            0, 1: msg_len = $urandom_range(0, 12);
            2: msg_len = $urandom_range(52, 64);
            3: msg_len = $urandom_range(56, 63);
            default: msg_len = $urandom_range(0, 140);
         endcase
         if (msg_len > RANDOM_ITEMS - items_sent)
            msg_len = RANDOM_ITEMS - items_sent;
         msg = {};
         repeat (msg_len) msg.push_back(8'($urandom));
         sender_quiet = ($urandom_range(0, 3) == 0);
         if (msg_count == PAUSE_MESSAGE)
            wait_until_drained();
         send_message(msg, $urandom_range(0, 1));
         msg_count++;
      end

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
